// ----- hdl/lpt_pkg.sv -----
`default_nettype none
package lpt_pkg;

   // field widths
   localparam int PixW   = 16;
   localparam int WordW  = 32;
   localparam int StatW  = 2;
   localparam int AddrW  = 5;
   localparam int IdxW   = AddrW - 2;

   // internal widths
   localparam int DiffW  = PixW + 1;             // u - cx
   localparam int PixMulW = DiffW + WordW + 1;   // (u - cx) * inv_f
   localparam int NormW  = PixMulW - 16;         // Xn, Yn in Q.20
   localparam int TermW  = WordW + NormW;        // a0 * Xn in Q.44
   localparam int DenW   = 62;                   // D in Q.40
   localparam int MagW   = DenW - 1;             // |D|
   localparam int DivSteps = 33;                 // quotient bits of |a2| * 2^41 / |D|
   localparam int ProdW  = NormW + WordW;        // Xn * Zc in Q.36
   localparam int ScaleW = ProdW - 20;           // rounded to Q16.16

   localparam logic signed [DenW-1:0] OneQ40 = DenW'(64'h0000_0100_0000_0000);

   // register map
   localparam logic [IdxW-1:0] REG_INV_FX   = 3'd0;
   localparam logic [IdxW-1:0] REG_INV_FY   = 3'd1;
   localparam logic [IdxW-1:0] REG_CENTER_X = 3'd2;
   localparam logic [IdxW-1:0] REG_CENTER_Y = 3'd3;
   localparam logic [IdxW-1:0] REG_SLOPE_X  = 3'd4;
   localparam logic [IdxW-1:0] REG_SLOPE_Y  = 3'd5;
   localparam logic [IdxW-1:0] REG_OFFSET   = 3'd6;

   localparam logic [WordW-1:0] InvFocalReset = 32'd4294967;
   localparam logic [PixW-1:0]  CenterXReset  = 16'd10240;
   localparam logic [PixW-1:0]  CenterYReset  = 16'd7680;

   // status codes
   localparam logic [StatW-1:0] STATUS_OK       = 2'd0;
   localparam logic [StatW-1:0] STATUS_PARALLEL = 2'd1;
   localparam logic [StatW-1:0] STATUS_SAT      = 2'd2;

   typedef struct packed {
      logic [PixW-1:0] pixel_u;
      logic [PixW-1:0] pixel_v;
   } req_word_type;

   typedef struct packed {
      logic signed [WordW-1:0] cam_x;
      logic signed [WordW-1:0] cam_y;
      logic signed [WordW-1:0] cam_z;
      logic [StatW-1:0]        status;
   } rsp_word_type;

   typedef struct packed {
      logic [WordW-1:0]        inv_focal_x;
      logic [WordW-1:0]        inv_focal_y;
      logic [PixW-1:0]         center_x;
      logic [PixW-1:0]         center_y;
      logic signed [WordW-1:0] plane_slope_x;
      logic signed [WordW-1:0] plane_slope_y;
      logic signed [WordW-1:0] plane_offset;
   } cfg_type;

   typedef struct packed {
      logic signed [NormW-1:0] xn;
      logic signed [NormW-1:0] yn;
   } norm_type;

   typedef struct packed {
      norm_type                norm;
      logic                    parallel;
      logic                    neg;
      logic                    ovf;
      logic [MagW-1:0]         dmag;
      logic [MagW-1:0]         rem;
      logic [DivSteps-1:0]     quot;
   } div_type;

endpackage
`default_nettype wire

// ----- hdl/laser_plane_pixel_triangulation.sv -----
`default_nettype none
// Channel   Direction  Handshake                 Word
// req       in         req_valid / req_ready     pixel_u, pixel_v (Q12.4)
// rsp       out        rsp_valid / rsp_ready     cam_x, cam_y, cam_z (Q16.16), status
// csr       in/out     csr_psel / csr_penable    APB register port, pready tied high
//
// One word per cycle sustained while the output is not held; from accept to
// rsp_valid: 7 front, 33 divider (one quotient bit each) and 3 back stages.
// Reset clears all valid bits and loads the register defaults.
// The whole pipeline holds while the output word waits; a one-word skid on
// the input takes one more word during that time.
module laser_plane_pixel_triangulation (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lpt_pkg::req_word_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lpt_pkg::rsp_word_type       rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lpt_pkg::AddrW-1:0]   csr_paddr,
   input  logic [lpt_pkg::WordW-1:0]   csr_pwdata,
   output logic [lpt_pkg::WordW-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import lpt_pkg::*;

   logic            en;
   logic            req_acc;
   logic            skid_valid_ff, skid_valid_in;
   req_word_type    skid_word_ff, skid_word_in;
   logic            front_valid;
   req_word_type    front_word;
   cfg_type         cfg_ff, cfg_in;
   logic            csr_wr;
   logic [IdxW-1:0] reg_idx;

   logic [DivSteps:0] div_valid;
   div_type           div_word [0:DivSteps];

   assign en      = ~rsp_valid | rsp_ready;
   assign req_ready = ~skid_valid_ff;
   assign req_acc = req_valid & ~skid_valid_ff;

   always_comb begin
      skid_valid_in = skid_valid_ff ? ~en : (req_acc & ~en);
      skid_word_in  = skid_valid_ff ? skid_word_ff : req_data;
      front_valid   = skid_valid_ff | req_acc;
      front_word    = skid_valid_ff ? skid_word_ff : req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_word_ff <= skid_word_in;
   end

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[AddrW-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_INV_FX:   cfg_in.inv_focal_x   = csr_pwdata;
            REG_INV_FY:   cfg_in.inv_focal_y   = csr_pwdata;
            REG_CENTER_X: cfg_in.center_x      = csr_pwdata[PixW-1:0];
            REG_CENTER_Y: cfg_in.center_y      = csr_pwdata[PixW-1:0];
            REG_SLOPE_X:  cfg_in.plane_slope_x = csr_pwdata;
            REG_SLOPE_Y:  cfg_in.plane_slope_y = csr_pwdata;
            REG_OFFSET:   cfg_in.plane_offset  = csr_pwdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_INV_FX:   csr_prdata = cfg_ff.inv_focal_x;
         REG_INV_FY:   csr_prdata = cfg_ff.inv_focal_y;
         REG_CENTER_X: csr_prdata = WordW'(cfg_ff.center_x);
         REG_CENTER_Y: csr_prdata = WordW'(cfg_ff.center_y);
         REG_SLOPE_X:  csr_prdata = cfg_ff.plane_slope_x;
         REG_SLOPE_Y:  csr_prdata = cfg_ff.plane_slope_y;
         REG_OFFSET:   csr_prdata = cfg_ff.plane_offset;
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_focal_x   <= InvFocalReset;
         cfg_ff.inv_focal_y   <= InvFocalReset;
         cfg_ff.center_x      <= CenterXReset;
         cfg_ff.center_y      <= CenterYReset;
         cfg_ff.plane_slope_x <= '0;
         cfg_ff.plane_slope_y <= '0;
         cfg_ff.plane_offset  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_word   (front_word),
      .cfg       (cfg_ff),
      .out_valid (div_valid[0]),
      .out_div   (div_word[0])
   );

   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      lpt_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[i]),
         .in_div    (div_word[i]),
         .out_valid (div_valid[i+1]),
         .out_div   (div_word[i+1])
      );
   end

   lpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid[DivSteps]),
      .in_div    (div_word[DivSteps]),
      .out_valid (rsp_valid),
      .out_word  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- hdl/lpt_front.sv -----
`default_nettype none
module lpt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  lpt_pkg::req_word_type in_word,
   input  lpt_pkg::cfg_type      cfg,
   output logic                  out_valid,
   output lpt_pkg::div_type      out_div
);
   import lpt_pkg::*;

   localparam int Stages = 7;

   logic [Stages-1:0] valid_ff, valid_in;

   logic signed [DiffW-1:0]   du_ff, du_in, dv_ff, dv_in;
   logic signed [PixMulW-1:0] pu_ff, pu_in, pv_ff, pv_in;
   logic signed [PixMulW-1:0] pu_adj, pv_adj;
   norm_type                  norm3_ff, norm3_in;
   logic signed [TermW-1:0]   ta_ff, ta_in, tb_ff, tb_in;
   logic signed [TermW-1:0]   ta_adj, tb_adj;
   norm_type                  norm4_ff, norm5_ff, norm6_ff;
   logic signed [DenW-1:0]    ra_ff, ra_in, rb_ff, rb_in;
   logic signed [DenW-1:0]    den_ff, den_in;
   logic signed [DenW-1:0]    den_abs;
   logic [WordW-1:0]          num;
   div_type                   div_ff, div_in;

   assign valid_in = {valid_ff[Stages-2:0], in_valid};

   always_comb begin
      // offsets from the principal point
      du_in = {1'b0, in_word.pixel_u} - {1'b0, cfg.center_x};
      dv_in = {1'b0, in_word.pixel_v} - {1'b0, cfg.center_y};
      pu_in = du_ff * $signed({1'b0, cfg.inv_focal_x});
      pv_in = dv_ff * $signed({1'b0, cfg.inv_focal_y});
      // round half away from zero: add half, less one when negative
      pu_adj = pu_ff + $signed(PixMulW'(32767)) + $signed({{(PixMulW-1){1'b0}}, ~pu_ff[PixMulW-1]});
      pv_adj = pv_ff + $signed(PixMulW'(32767)) + $signed({{(PixMulW-1){1'b0}}, ~pv_ff[PixMulW-1]});
      norm3_in.xn = NormW'(pu_adj >>> 16);
      norm3_in.yn = NormW'(pv_adj >>> 16);
      ta_in = cfg.plane_slope_x * norm3_ff.xn;
      tb_in = cfg.plane_slope_y * norm3_ff.yn;
      ta_adj = ta_ff + $signed(TermW'(7)) + $signed({{(TermW-1){1'b0}}, ~ta_ff[TermW-1]});
      tb_adj = tb_ff + $signed(TermW'(7)) + $signed({{(TermW-1){1'b0}}, ~tb_ff[TermW-1]});
      ra_in = DenW'(ta_adj >>> 4);
      rb_in = DenW'(tb_adj >>> 4);
      den_in = ra_ff + rb_ff - OneQ40;
   end

   always_comb begin
      den_abs = den_ff[DenW-1] ? -den_ff : den_ff;
      num = cfg.plane_offset[WordW-1] ? WordW'(-cfg.plane_offset) : cfg.plane_offset;
      div_in.norm     = norm6_ff;
      div_in.parallel = (den_ff == '0);
      div_in.neg      = (cfg.plane_offset[WordW-1] == den_ff[DenW-1]);
      div_in.dmag     = den_abs[MagW-1:0];
      // quotient needs more than DivSteps bits: Zc saturates regardless
      div_in.ovf      = (MagW'({num, 8'd0}) >= den_abs[MagW-1:0]);
      div_in.rem      = MagW'({num, 8'd0});
      div_in.quot     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         du_ff    <= du_in;
         dv_ff    <= dv_in;
         pu_ff    <= pu_in;
         pv_ff    <= pv_in;
         norm3_ff <= norm3_in;
         ta_ff    <= ta_in;
         tb_ff    <= tb_in;
         norm4_ff <= norm3_ff;
         ra_ff    <= ra_in;
         rb_ff    <= rb_in;
         norm5_ff <= norm4_ff;
         den_ff   <= den_in;
         norm6_ff <= norm5_ff;
         div_ff   <= div_in;
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_div   = div_ff;

endmodule
`default_nettype wire

// ----- hdl/lpt_div_stage.sv -----
`default_nettype none
module lpt_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  lpt_pkg::div_type in_div,
   output logic             out_valid,
   output lpt_pkg::div_type out_div
);
   import lpt_pkg::*;

   logic            valid_ff;
   div_type         div_ff, div_in;
   logic [MagW:0]   two_r;
   logic [MagW:0]   diff;
   logic            ge;

   // one restoring step: one quotient bit
   always_comb begin
      two_r = {in_div.rem, 1'b0};
      diff  = two_r - {1'b0, in_div.dmag};
      ge    = (two_r >= {1'b0, in_div.dmag});
      div_in      = in_div;
      div_in.rem  = ge ? diff[MagW-1:0] : two_r[MagW-1:0];
      div_in.quot = {in_div.quot[DivSteps-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;

endmodule
`default_nettype wire

// ----- hdl/lpt_back.sv -----
`default_nettype none
module lpt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  lpt_pkg::div_type      in_div,
   output logic                  out_valid,
   output lpt_pkg::rsp_word_type out_word
);
   import lpt_pkg::*;

   localparam logic signed [WordW-1:0] S32Max = 32'sh7FFF_FFFF;
   localparam logic signed [WordW-1:0] S32Min = 32'sh8000_0000;
   localparam logic [DivSteps-1:0]     QPosLim = DivSteps'(64'h7FFF_FFFF);
   localparam logic [DivSteps-1:0]     QNegLim = DivSteps'(64'h8000_0000);

   logic [2:0] valid_ff, valid_in;

   logic [DivSteps:0]          qp;
   logic [DivSteps-1:0]        q;
   logic signed [WordW-1:0]    zc1_ff, zc1_in, zc2_ff;
   logic                       zsat1_ff, zsat1_in, zsat2_ff;
   logic                       par1_ff, par2_ff;
   norm_type                   norm1_ff;
   logic signed [ProdW-1:0]    px_ff, px_in, py_ff, py_in;
   logic signed [ProdW-1:0]    px_adj, py_adj;
   logic [WordW:0]             xc_clamp, yc_clamp;
   rsp_word_type               word_ff, word_in;

   function automatic logic [WordW:0] clamp32(input logic signed [ScaleW-1:0] v);
      logic [WordW:0] r;
      if (v > ScaleW'(S32Max)) begin
         r = {1'b1, S32Max};
      end else if (v < ScaleW'(S32Min)) begin
         r = {1'b1, S32Min};
      end else begin
         r = {1'b0, v[WordW-1:0]};
      end
      return r;
   endfunction

   assign valid_in = {valid_ff[1:0], in_valid};

   // stage 1: round the quotient to Q16.16 and apply the sign of Zc
   always_comb begin
      qp = {1'b0, in_div.quot} + (DivSteps+1)'(1);
      q  = qp[DivSteps:1];
      zsat1_in = 1'b0;
      zc1_in   = '0;
      if (in_div.ovf) begin
         zsat1_in = 1'b1;
         zc1_in   = in_div.neg ? S32Min : S32Max;
      end else if (in_div.neg) begin
         if (q > QNegLim) begin
            zsat1_in = 1'b1;
            zc1_in   = S32Min;
         end else begin
            zc1_in = -q[WordW-1:0];
         end
      end else begin
         if (q > QPosLim) begin
            zsat1_in = 1'b1;
            zc1_in   = S32Max;
         end else begin
            zc1_in = q[WordW-1:0];
         end
      end
   end

   // stage 2: scale the normalized ray by the depth
   always_comb begin
      px_in = norm1_ff.xn * zc1_ff;
      py_in = norm1_ff.yn * zc1_ff;
   end

   // stage 3: round Q.36 to Q16.16, clamp, form the word
   always_comb begin
      px_adj = px_ff + $signed(ProdW'(524287)) + $signed({{(ProdW-1){1'b0}}, ~px_ff[ProdW-1]});
      py_adj = py_ff + $signed(ProdW'(524287)) + $signed({{(ProdW-1){1'b0}}, ~py_ff[ProdW-1]});
      xc_clamp = clamp32(ScaleW'(px_adj >>> 20));
      yc_clamp = clamp32(ScaleW'(py_adj >>> 20));
      if (par2_ff) begin
         word_in.cam_x  = '0;
         word_in.cam_y  = '0;
         word_in.cam_z  = '0;
         word_in.status = STATUS_PARALLEL;
      end else begin
         word_in.cam_x  = xc_clamp[WordW-1:0];
         word_in.cam_y  = yc_clamp[WordW-1:0];
         word_in.cam_z  = zc2_ff;
         word_in.status = (zsat2_ff | xc_clamp[WordW] | yc_clamp[WordW]) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zc1_ff   <= zc1_in;
         zsat1_ff <= zsat1_in;
         par1_ff  <= in_div.parallel;
         norm1_ff <= in_div.norm;
         px_ff    <= px_in;
         py_ff    <= py_in;
         zc2_ff   <= zc1_ff;
         zsat2_ff <= zsat1_ff;
         par2_ff  <= par1_ff;
         word_ff  <= word_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_word  = word_ff;

endmodule
`default_nettype wire
